/* design/dilepton_invariant_mass_unit_defines.svh */
// Assertion macros for the dilepton invariant mass unit.
// Depends on nothing; the asserting file supplies clk and rst_n.
`ifndef DILEPTON_INVARIANT_MASS_UNIT_DEFINES_SVH
`define DILEPTON_INVARIANT_MASS_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define DIM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dim assertion failed");

// Next-cycle implication, disabled during reset.
`define DIM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dim assertion failed");

`endif

/* design/dim_pkg.sv */
// Shared widths, codes and sideband type of the dilepton invariant mass unit.
// No dependencies.
package dim_pkg;

  localparam int MomW    = 36;
  localparam int MassW   = 20;
  localparam int OutW    = 37;
  localparam int SqInW   = 37;
  localparam int SqLoW   = 18;
  localparam int SqHiW   = SqInW - SqLoW;
  localparam int RootW   = 37;
  localparam int RadW    = 2 * RootW;
  localparam int RemW    = RootW + 2;
  localparam int SqrtSteps = RootW;
  localparam int NumSq   = 9;
  localparam int FlavW   = 2;
  localparam int CfgIdxW = 2;

  localparam logic [FlavW-1:0] FlavElectron = 2'd0;
  localparam logic [FlavW-1:0] FlavMuon     = 2'd1;

  localparam logic [CfgIdxW-1:0] CfgElectronMass = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMuonMass     = 2'd1;

  localparam logic [MassW-1:0] ElectronMassReset = 20'd511;
  localparam logic [MassW-1:0] MuonMassReset     = 20'd105658;

  // Sideband carried alongside a square root pipeline.
  typedef struct packed {
    logic            ok;
    logic            neg;
    logic [RadW-1:0] p2;
  } side_t;

  function automatic logic [SqInW-1:0] mag(input logic [SqInW-1:0] v);
    mag = v[SqInW-1] ? (~v + 1'b1) : v;
  endfunction

endpackage

/* design/dim_sq.sv */
// Two-stage pipelined squarer of a 37-bit unsigned value, split into 19-bit and 18-bit parts.
// Depends on dim_pkg.
module dim_sq (
  input  logic                      clk,
  input  logic                      en,
  input  logic [dim_pkg::SqInW-1:0] a,
  output logic [dim_pkg::RadW-1:0]  q
);
  import dim_pkg::*;

  logic [SqHiW-1:0]         hi;
  logic [SqLoW-1:0]         lo;
  logic [2*SqHiW-1:0]       hh_r;
  logic [SqHiW+SqLoW-1:0]   hl_r;
  logic [2*SqLoW-1:0]       ll_r;
  logic [RadW-1:0]          q_r;

  assign hi = a[SqInW-1:SqLoW];
  assign lo = a[SqLoW-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      hh_r <= hi * hi;
      hl_r <= hi * lo;
      ll_r <= lo * lo;
      q_r  <= {hh_r, {(2*SqLoW){1'b0}}}
            + {{(RadW-(SqHiW+SqLoW)-SqLoW-1){1'b0}}, hl_r, {(SqLoW+1){1'b0}}}
            + {{(RadW-2*SqLoW){1'b0}}, ll_r};
    end
  end

  assign q = q_r;
endmodule

/* design/dim_sqrt.sv */
// Fully pipelined floor square root, one result bit per stage, with sideband.
// Depends on dim_pkg.
module dim_sqrt (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_v,
  input  logic [dim_pkg::RadW-1:0]  in_rad,
  input  dim_pkg::side_t            in_side,
  output logic                      out_v,
  output logic [dim_pkg::RootW-1:0] out_root,
  output dim_pkg::side_t            out_side
);
  import dim_pkg::*;

  logic             v_r    [SqrtSteps];
  logic [RadW-1:0]  rad_r  [SqrtSteps];
  logic [RootW-1:0] root_r [SqrtSteps];
  logic [RemW-1:0]  rem_r  [SqrtSteps];
  side_t            side_r [SqrtSteps];

  genvar k;
  generate
    for (k = 0; k < SqrtSteps; k++) begin : g_step
      logic             pv;
      logic [RadW-1:0]  prad;
      logic [RootW-1:0] proot;
      logic [RemW-1:0]  prem;
      side_t            pside;
      logic [RemW-1:0]  cur;
      logic [RemW-1:0]  trial;
      logic [RemW-1:0]  rem_nxt;
      logic [RootW-1:0] root_nxt;

      if (k == 0) begin : g_first
        assign pv    = in_v;
        assign prad  = in_rad;
        assign proot = '0;
        assign prem  = '0;
        assign pside = in_side;
      end else begin : g_rest
        assign pv    = v_r[k-1];
        assign prad  = rad_r[k-1];
        assign proot = root_r[k-1];
        assign prem  = rem_r[k-1];
        assign pside = side_r[k-1];
      end

      // Bring down two radicand bits and try appending a one to the root.
      always_comb begin
        cur   = {prem[RemW-3:0], prad[RadW-1 -: 2]};
        trial = {proot, 2'b01};
        if (cur >= trial) begin
          rem_nxt  = cur - trial;
          root_nxt = {proot[RootW-2:0], 1'b1};
        end else begin
          rem_nxt  = cur;
          root_nxt = {proot[RootW-2:0], 1'b0};
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[k] <= 1'b0;
        end else if (en) begin
          v_r[k] <= pv;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rad_r[k]  <= {prad[RadW-3:0], 2'b00};
          root_r[k] <= root_nxt;
          rem_r[k]  <= rem_nxt;
          side_r[k] <= pside;
        end
      end
    end
  endgenerate

  assign out_v    = v_r[SqrtSteps-1];
  assign out_root = root_r[SqrtSteps-1];
  assign out_side = side_r[SqrtSteps-1];
endmodule

/* design/dilepton_invariant_mass_unit.sv */
// Throughput: one pair per cycle while the skid entry is empty; the 37-stage energy
// and mass square root pipelines set most of the depth.
// A stalled output beat parks the next result in a one-entry skid buffer; the pipeline
// and in_ready then hold until that entry drains.
// Reset (rst_n, synchronous, active low) clears all valid bits and loads the default
// electron and muon masses into the configuration registers.
module dilepton_invariant_mass_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [dim_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [dim_pkg::MassW-1:0]   cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [dim_pkg::FlavW-1:0]   in_first_flavor,
  input  logic signed [dim_pkg::MomW-1:0] in_first_mom_x,
  input  logic signed [dim_pkg::MomW-1:0] in_first_mom_y,
  input  logic signed [dim_pkg::MomW-1:0] in_first_mom_z,
  input  logic [dim_pkg::FlavW-1:0]   in_second_flavor,
  input  logic signed [dim_pkg::MomW-1:0] in_second_mom_x,
  input  logic signed [dim_pkg::MomW-1:0] in_second_mom_y,
  input  logic signed [dim_pkg::MomW-1:0] in_second_mom_z,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [dim_pkg::OutW-1:0]    out_pair_mass,
  output logic                        out_mass_valid,
  output logic                        out_radicand_negative
);
  import dim_pkg::*;
  `include "dilepton_invariant_mass_unit_defines.svh"

  // The whole pipeline moves together; it only stops when the skid entry is occupied.
  logic en;

  // Configuration registers.
  logic [MassW-1:0] e_mass_r;
  logic [MassW-1:0] mu_mass_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_mass_r  <= ElectronMassReset;
      mu_mass_r <= MuonMassReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CfgElectronMass: e_mass_r  <= cfg_data;
        CfgMuonMass:     mu_mass_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage A: register the accepted beat.
  logic             a_v_r;
  logic [FlavW-1:0] a_f1_r, a_f2_r;
  logic [MomW-1:0]  a_p_r [6];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_f1_r   <= in_first_flavor;
      a_f2_r   <= in_second_flavor;
      a_p_r[0] <= in_first_mom_x;
      a_p_r[1] <= in_first_mom_y;
      a_p_r[2] <= in_first_mom_z;
      a_p_r[3] <= in_second_mom_x;
      a_p_r[4] <= in_second_mom_y;
      a_p_r[5] <= in_second_mom_z;
    end
  end

  // Stage B: magnitudes of the six components and of the three summed components,
  // plus the flavor masses. A flavor above muon marks the pair as unusable.
  logic             b_v_r, b_ok_r;
  logic [SqInW-1:0] b_mag_r [NumSq];
  logic [MassW-1:0] b_m1_r, b_m2_r;
  logic [SqInW-1:0] ext [6];
  logic [SqInW-1:0] psum [3];

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      ext[i] = {a_p_r[i][MomW-1], a_p_r[i]};
    end
    for (int i = 0; i < 3; i++) begin
      psum[i] = ext[i] + ext[i+3];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (en) begin
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_ok_r <= (a_f1_r == FlavElectron || a_f1_r == FlavMuon)
             && (a_f2_r == FlavElectron || a_f2_r == FlavMuon);
      b_m1_r <= (a_f1_r == FlavElectron) ? e_mass_r : mu_mass_r;
      b_m2_r <= (a_f2_r == FlavElectron) ? e_mass_r : mu_mass_r;
      for (int i = 0; i < 6; i++) begin
        b_mag_r[i] <= mag(ext[i]);
      end
      for (int i = 0; i < 3; i++) begin
        b_mag_r[6+i] <= mag(psum[i]);
      end
    end
  end

  // Stages C and D: nine squarers and the two mass squares.
  logic [RadW-1:0]    sq_q [NumSq];
  logic               c_v_r, d_v_r, c_ok_r, d_ok_r;
  logic [2*MassW-1:0] c_msq1_r, c_msq2_r, d_msq1_r, d_msq2_r;

  genvar g;
  generate
    for (g = 0; g < NumSq; g++) begin : g_sq
      dim_sq u_sq (
        .clk (clk),
        .en  (en),
        .a   (b_mag_r[g]),
        .q   (sq_q[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
      d_v_r <= 1'b0;
    end else if (en) begin
      c_v_r <= b_v_r;
      d_v_r <= c_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_ok_r   <= b_ok_r;
      d_ok_r   <= c_ok_r;
      c_msq1_r <= b_m1_r * b_m1_r;
      c_msq2_r <= b_m2_r * b_m2_r;
      d_msq1_r <= c_msq1_r;
      d_msq2_r <= c_msq2_r;
    end
  end

  // Stages E and F: add the squares in two rounds of pairwise sums.
  logic            e_v_r, e_ok_r, f_v_r, f_ok_r;
  logic [RadW-1:0] e_s1a_r, e_s1b_r, e_s2a_r, e_s2b_r, e_pa_r, e_pb_r;
  logic [RadW-1:0] f_r1_r, f_r2_r, f_p2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_v_r <= 1'b0;
      f_v_r <= 1'b0;
    end else if (en) begin
      e_v_r <= d_v_r;
      f_v_r <= e_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_ok_r  <= d_ok_r;
      e_s1a_r <= sq_q[0] + sq_q[1];
      e_s1b_r <= sq_q[2] + {{(RadW-2*MassW){1'b0}}, d_msq1_r};
      e_s2a_r <= sq_q[3] + sq_q[4];
      e_s2b_r <= sq_q[5] + {{(RadW-2*MassW){1'b0}}, d_msq2_r};
      e_pa_r  <= sq_q[6] + sq_q[7];
      e_pb_r  <= sq_q[8];
      f_ok_r  <= e_ok_r;
      f_r1_r  <= e_s1a_r + e_s1b_r;
      f_r2_r  <= e_s2a_r + e_s2b_r;
      f_p2_r  <= e_pa_r + e_pb_r;
    end
  end

  // Energy square roots. The first root carries the pair sideband; the second runs
  // in lockstep and needs none.
  side_t            f_side;
  side_t            g_side;
  logic             g_v;
  logic [RootW-1:0] g_e1, g_e2;

  assign f_side = '{ok: f_ok_r, neg: 1'b0, p2: f_p2_r};

  dim_sqrt u_sqrt_e1 (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (f_v_r),
    .in_rad   (f_r1_r),
    .in_side  (f_side),
    .out_v    (g_v),
    .out_root (g_e1),
    .out_side (g_side)
  );

  dim_sqrt u_sqrt_e2 (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (f_v_r),
    .in_rad   (f_r2_r),
    .in_side  ('0),
    .out_v    (),
    .out_root (g_e2),
    .out_side ()
  );

  // Stage H: energy sum. Both energies stay below 2^36, so the sum fits 37 bits.
  logic             h_v_r, h_ok_r;
  logic [RadW-1:0]  h_p2_r;
  logic [SqInW-1:0] h_esum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_v_r <= 1'b0;
    end else if (en) begin
      h_v_r <= g_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h_ok_r   <= g_side.ok;
      h_p2_r   <= g_side.p2;
      h_esum_r <= g_e1 + g_e2;
    end
  end

  // Stages I and J: square the energy sum while the momentum square waits alongside.
  logic            i_v_r, j_v_r, i_ok_r, j_ok_r;
  logic [RadW-1:0] i_p2_r, j_p2_r;
  logic [RadW-1:0] esq;

  dim_sq u_sq_esum (
    .clk (clk),
    .en  (en),
    .a   (h_esum_r),
    .q   (esq)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_v_r <= 1'b0;
      j_v_r <= 1'b0;
    end else if (en) begin
      i_v_r <= h_v_r;
      j_v_r <= i_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      i_ok_r <= h_ok_r;
      j_ok_r <= i_ok_r;
      i_p2_r <= h_p2_r;
      j_p2_r <= i_p2_r;
    end
  end

  // Stage K: final radicand. Floored energies can leave it negative; the borrow
  // flags that case and the radicand is clamped to zero.
  logic            k_v_r, k_ok_r, k_neg_r;
  logic [RadW-1:0] k_rad_r;
  logic [RadW:0]   diff;

  assign diff = {1'b0, esq} - {1'b0, j_p2_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_v_r <= 1'b0;
    end else if (en) begin
      k_v_r <= j_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k_ok_r  <= j_ok_r;
      k_neg_r <= diff[RadW];
      k_rad_r <= diff[RadW] ? '0 : diff[RadW-1:0];
    end
  end

  // Final square root.
  side_t            k_side;
  side_t            m_side;
  logic             m_v;
  logic [RootW-1:0] m_root;

  assign k_side = '{ok: k_ok_r, neg: k_neg_r, p2: '0};

  dim_sqrt u_sqrt_mass (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (k_v_r),
    .in_rad   (k_rad_r),
    .in_side  (k_side),
    .out_v    (m_v),
    .out_root (m_root),
    .out_side (m_side)
  );

  // Result shaping: an unusable pair reports all zeros.
  logic [OutW-1:0] res_mass;
  logic            res_ok, res_neg;

  assign res_ok   = m_side.ok;
  assign res_neg  = m_side.ok & m_side.neg;
  assign res_mass = m_side.ok ? m_root : '0;

  // Output register with a one-entry skid buffer. A result that arrives while the
  // output beat is stalled parks in the skid entry, and the pipeline then holds.
  logic            out_v_r, skid_v_r;
  logic [OutW-1:0] out_mass_r, skid_mass_r;
  logic            out_ok_r, out_neg_r, skid_ok_r, skid_neg_r;

  assign en = !skid_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_ready || !out_v_r) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= m_v;
      end
    end else if (m_v && !skid_v_r) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready || !out_v_r) begin
      if (skid_v_r) begin
        out_mass_r <= skid_mass_r;
        out_ok_r   <= skid_ok_r;
        out_neg_r  <= skid_neg_r;
      end else begin
        out_mass_r <= res_mass;
        out_ok_r   <= res_ok;
        out_neg_r  <= res_neg;
      end
    end else if (!skid_v_r) begin
      skid_mass_r <= res_mass;
      skid_ok_r   <= res_ok;
      skid_neg_r  <= res_neg;
    end
  end

  assign in_ready              = en;
  assign out_valid             = out_v_r;
  assign out_pair_mass         = out_mass_r;
  assign out_mass_valid        = out_ok_r;
  assign out_radicand_negative = out_neg_r;

  // The skid entry only fills behind a stalled output beat.
  `DIM_ASSERT_NOW(a_skid_behind_out, skid_v_r, out_v_r)
  // While the skid entry is occupied no new beat is taken.
  `DIM_ASSERT_NOW(a_skid_blocks_in, skid_v_r, !in_ready)
  // An unusable pair reports zero mass and no negative flag.
  `DIM_ASSERT_NOW(a_invalid_zero, out_valid && !out_mass_valid, out_pair_mass == '0 && !out_radicand_negative)
  // A clamped radicand yields zero mass.
  `DIM_ASSERT_NOW(a_neg_zero, out_valid && out_radicand_negative, out_pair_mass == '0)
endmodule

/* verif/dim_checker.sv */
// Scoreboard for the dilepton invariant mass unit: it mirrors the mass registers,
// predicts every pair mass and compares the result beats. Depends on dim_pkg.
module dim_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [dim_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [dim_pkg::MassW-1:0]       cfg_data,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [dim_pkg::FlavW-1:0]       in_first_flavor,
  input  logic signed [dim_pkg::MomW-1:0] in_first_mom_x,
  input  logic signed [dim_pkg::MomW-1:0] in_first_mom_y,
  input  logic signed [dim_pkg::MomW-1:0] in_first_mom_z,
  input  logic [dim_pkg::FlavW-1:0]       in_second_flavor,
  input  logic signed [dim_pkg::MomW-1:0] in_second_mom_x,
  input  logic signed [dim_pkg::MomW-1:0] in_second_mom_y,
  input  logic signed [dim_pkg::MomW-1:0] in_second_mom_z,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [dim_pkg::OutW-1:0]        out_pair_mass,
  input  logic                            out_mass_valid,
  input  logic                            out_radicand_negative,
  output int                              errors,
  output int                              pending,
  output int                              checked,
  output int                              neg_seen,
  output int                              invalid_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import dim_pkg::*;

  typedef struct {
    logic [OutW-1:0] mass;
    logic            ok;
    logic            neg;
  } pair_result_t;

  pair_result_t    mass_fifo[$];
  logic [MassW-1:0] e_mass, mu_mass;

  function automatic logic [127:0] floor_root(input logic [127:0] n);
    logic [63:0] r, c;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      c = r | (64'd1 << i);
      if ({64'd0, c} * {64'd0, c} <= n) r = c;
    end
    return {64'd0, r};
  endfunction

  function automatic logic [127:0] square(input logic signed [63:0] v);
    logic [127:0] m;
    m = {64'd0, (v < 0) ? -v : v};
    return m * m;
  endfunction

  function automatic logic [127:0] lepton_energy(input logic signed [63:0] x,
      input logic signed [63:0] y, input logic signed [63:0] z, input logic [MassW-1:0] m);
    logic [127:0] mm;
    mm = {108'd0, m};
    return floor_root(square(x) + square(y) + square(z) + mm * mm);
  endfunction

  function automatic pair_result_t predict_pair(input logic [FlavW-1:0] f1,
      input logic signed [63:0] x1, input logic signed [63:0] y1,
      input logic signed [63:0] z1, input logic [FlavW-1:0] f2,
      input logic signed [63:0] x2, input logic signed [63:0] y2,
      input logic signed [63:0] z2);
    pair_result_t res;
    logic [127:0] esum, e2, p2;
    logic [MassW-1:0] m1, m2;
    res = '{mass: '0, ok: 1'b0, neg: 1'b0};
    if (f1 != FlavElectron && f1 != FlavMuon) return res;
    if (f2 != FlavElectron && f2 != FlavMuon) return res;
    m1 = (f1 == FlavElectron) ? e_mass : mu_mass;
    m2 = (f2 == FlavElectron) ? e_mass : mu_mass;
    esum = lepton_energy(x1, y1, z1, m1) + lepton_energy(x2, y2, z2, m2);
    e2 = esum * esum;
    p2 = square(x1 + x2) + square(y1 + y2) + square(z1 + z2);
    res.ok = 1'b1;
    if (p2 > e2) begin
      res.neg = 1'b1;
      return res;
    end
    res.mass = OutW'(floor_root(e2 - p2));
    return res;
  endfunction

  always @(posedge clk) begin
    pair_result_t exp_r;
    if (!rst_n) begin
      e_mass = ElectronMassReset;
      mu_mass = MuonMassReset;
      mass_fifo.delete();
      errors = 0; checked = 0; neg_seen = 0; invalid_seen = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (mass_fifo.size() == 0) begin
          $error("result beat with no pair outstanding");
          errors++;
        end else begin
          exp_r = mass_fifo.pop_front();
          if (out_pair_mass !== exp_r.mass) begin
            $error("pair_mass expected %0d got %0d", exp_r.mass, out_pair_mass);
            errors++;
          end
          if (out_mass_valid !== exp_r.ok) begin
            $error("mass_valid expected %0d got %0d", exp_r.ok, out_mass_valid);
            errors++;
          end
          if (out_radicand_negative !== exp_r.neg) begin
            $error("radicand_negative expected %0d got %0d", exp_r.neg,
                   out_radicand_negative);
            errors++;
          end
          checked++;
          if (exp_r.neg) neg_seen++;
          if (!exp_r.ok) invalid_seen++;
        end
      end
      // Input beats are predicted with the masses in force before this edge's write.
      if (in_valid && in_ready)
        mass_fifo.push_back(predict_pair(in_first_flavor, in_first_mom_x, in_first_mom_y,
            in_first_mom_z, in_second_flavor, in_second_mom_x, in_second_mom_y,
            in_second_mom_z));
      if (cfg_we) begin
        if (cfg_index == CfgElectronMass) e_mass = cfg_data;
        else if (cfg_index == CfgMuonMass) mu_mass = cfg_data;
      end
    end
    pending = mass_fifo.size();
  end

endmodule

/* verif/tb.sv */
// Top of the dilepton invariant mass testbench: clock, reset, pair stimulus and verdict.
// Depends on dim_pkg, dim_checker and the dilepton_invariant_mass_unit RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dim_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgSpareA = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpareB = 2'd3;
  localparam logic [FlavW-1:0]   FlavOther = 2'd2;
  localparam logic [FlavW-1:0]   FlavSpare = 2'd3;
  localparam logic signed [MomW-1:0] MomMax = {1'b0, {(MomW-1){1'b1}}};
  localparam logic signed [MomW-1:0] MomMin = {1'b1, {(MomW-1){1'b0}}};

  logic clk, rst_n;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [MassW-1:0] cfg_data;
  logic in_valid, in_ready;
  logic [FlavW-1:0] in_first_flavor, in_second_flavor;
  logic signed [MomW-1:0] in_first_mom_x, in_first_mom_y, in_first_mom_z;
  logic signed [MomW-1:0] in_second_mom_x, in_second_mom_y, in_second_mom_z;
  logic out_valid, out_ready;
  logic [OutW-1:0] out_pair_mass;
  logic out_mass_valid, out_radicand_negative;
  int errors, pending, checked, neg_seen, invalid_seen;
  int recv_stall_pct;

  dilepton_invariant_mass_unit u_top (.*);
  dim_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // The receiver drops ready at random in the stall percentage of cycles.
  always @(posedge clk)
    out_ready <= ($urandom_range(99) >= recv_stall_pct);

  // Hard stop in case the block hangs on a handshake.
  initial begin
    #2_000_000;
    $display("dilepton_invariant_mass_unit: mismatch");
    $finish;
  end

  // A random momentum component with a random magnitude span, so that tiny,
  // middling and full-scale values all show up.
  function automatic logic signed [MomW-1:0] rand_mom();
    logic [63:0] v;
    int span;
    span = $urandom_range(MomW, 1);
    v = {$urandom, $urandom} & ((64'd1 << span) - 1);
    if ($urandom_range(1)) v = -v;
    return v[MomW-1:0];
  endfunction

  function automatic logic [FlavW-1:0] rand_flavor();
    // Mostly physical flavors; unknown codes appear now and then.
    return ($urandom_range(99) < 92) ? FlavW'($urandom_range(1)) : FlavW'($urandom_range(3, 2));
  endfunction

  // Presents one pair and holds it until the beat is taken. We are always at a
  // rising edge on entry and on exit. Ready is looked at on the falling edge,
  // where it is settled for the coming rising edge.
  task automatic send_pair(input logic [FlavW-1:0] f1, input logic signed [MomW-1:0] x1,
      input logic signed [MomW-1:0] y1, input logic signed [MomW-1:0] z1,
      input logic [FlavW-1:0] f2, input logic signed [MomW-1:0] x2,
      input logic signed [MomW-1:0] y2, input logic signed [MomW-1:0] z2);
    in_valid <= 1'b1;
    in_first_flavor <= f1;
    in_first_mom_x <= x1; in_first_mom_y <= y1; in_first_mom_z <= z1;
    in_second_flavor <= f2;
    in_second_mom_x <= x2; in_second_mom_y <= y2; in_second_mom_z <= z2;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
  endtask

  // Lets the pipeline drain completely, then allows some slack beyond the latency.
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_masses(input logic [MassW-1:0] e_val, input logic [MassW-1:0] mu_val);
    cfg_we <= 1'b1; cfg_index <= CfgElectronMass; cfg_data <= e_val;
    @(posedge clk);
    cfg_index <= CfgMuonMass; cfg_data <= mu_val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // The sender idles in about send_idle_pct cycles of a hundred.
  task automatic random_pairs(input int count, input int send_idle_pct);
    logic signed [MomW-1:0] x1, y1, z1, x2, y2, z2;
    int sh;
    for (int n = 0; n < count; n++) begin
      while ($urandom_range(99) < send_idle_pct) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      x1 = rand_mom(); y1 = rand_mom(); z1 = rand_mom();
      if ($urandom_range(99) < 30) begin
        // Nearly collinear leptons: small pair masses and floored-energy
        // rounding that can push the radicand below zero.
        sh = $urandom_range(6);
        x2 = (x1 >>> sh) + MomW'($signed($urandom_range(2)) - 1);
        y2 = y1 >>> sh;
        z2 = z1 >>> sh;
      end else begin
        x2 = rand_mom(); y2 = rand_mom(); z2 = rand_mom();
      end
      send_pair(rand_flavor(), x1, y1, z1, rand_flavor(), x2, y2, z2);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    in_valid = 1'b0;
    in_first_flavor = '0; in_second_flavor = '0;
    in_first_mom_x = '0; in_first_mom_y = '0; in_first_mom_z = '0;
    in_second_mom_x = '0; in_second_mom_y = '0; in_second_mom_z = '0;
    recv_stall_pct = 73;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed pairs with the reset masses: leptons at rest, full-scale
    // components of both signs, back-to-back and identical momenta, both
    // physical flavors in either order and pairings with both unknown codes.
    send_pair(FlavElectron, '0, '0, '0, FlavElectron, '0, '0, '0);
    send_pair(FlavMuon, '0, '0, '0, FlavMuon, '0, '0, '0);
    send_pair(FlavElectron, '0, '0, '0, FlavMuon, '0, '0, '0);
    send_pair(FlavMuon, MomMax, MomMax, MomMax, FlavMuon, MomMax, MomMax, MomMax);
    send_pair(FlavElectron, MomMin, MomMin, MomMin, FlavElectron, MomMin, MomMin, MomMin);
    send_pair(FlavMuon, MomMax, MomMin, MomMax, FlavElectron, MomMin, MomMax, MomMin);
    send_pair(FlavElectron, MomMin, MomMin, MomMin, FlavMuon, MomMax, MomMax, MomMax);
    send_pair(FlavElectron, 36'sd1000, 36'sd0, 36'sd0, FlavElectron, -36'sd1000, 36'sd0, 36'sd0);
    send_pair(FlavElectron, 36'sd3, 36'sd4, 36'sd0, FlavElectron, 36'sd3, 36'sd4, 36'sd0);
    send_pair(FlavOther, 36'sd5, 36'sd5, 36'sd5, FlavMuon, 36'sd5, 36'sd5, 36'sd5);
    send_pair(FlavMuon, 36'sd5, 36'sd5, 36'sd5, FlavOther, 36'sd5, 36'sd5, 36'sd5);
    send_pair(FlavSpare, MomMax, '0, '0, FlavElectron, '0, '0, MomMin);
    send_pair(FlavElectron, -36'sd1, -36'sd1, -36'sd1, FlavSpare, 36'sd1, 36'sd1, 36'sd1);
    send_pair(FlavSpare, '0, '0, '0, FlavOther, '0, '0, '0);
    random_pairs(450, 8);
    drain_pipeline();

    // Zero masses: energies are bare momentum roots, so collinear pairs hit
    // the zero and negative radicand cases. Receiver now mostly ready.
    write_masses('0, '0);
    send_pair(FlavElectron, 36'sd1, 36'sd1, 36'sd0, FlavElectron, 36'sd1, 36'sd1, 36'sd0);
    send_pair(FlavElectron, 36'sd2, 36'sd3, 36'sd0, FlavMuon, 36'sd2, 36'sd3, 36'sd0);
    send_pair(FlavMuon, 36'sd7, '0, '0, FlavMuon, 36'sd9, '0, '0);
    recv_stall_pct = 8;
    random_pairs(450, 73);
    drain_pipeline();

    // Largest masses; writes to the unused indexes must change nothing.
    write_masses({MassW{1'b1}}, {MassW{1'b1}});
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= CfgSpareA; cfg_data <= 20'd3;
    @(posedge clk);
    cfg_index <= CfgSpareB; cfg_data <= 20'd7;
    @(posedge clk);
    cfg_we <= 1'b0;
    recv_stall_pct = 0;
    random_pairs(250, 0);
    drain_pipeline();

    write_masses(MassW'($urandom_range(2000)), MassW'($urandom));
    random_pairs(250, 0);
    drain_pipeline();

    $display("Checked %0d pair results over four mass settings and three idling mixes.",
             checked);
    $display("Of those, %0d had an unknown flavor and %0d a clamped negative radicand.",
             invalid_seen, neg_seen);
    if (errors == 0) begin
      $display("dilepton_invariant_mass_unit: match");
    end else begin
      $display("dilepton_invariant_mass_unit: mismatch");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+design
design/dim_pkg.sv
design/dim_sq.sv
design/dim_sqrt.sv
design/dilepton_invariant_mass_unit.sv
verif/dim_checker.sv
verif/tb.sv
